// ===== rtl/dmh_pkg.sv =====
// Shared types, codes and constants of the deadline timer queue.
package dmh_pkg;

    localparam int DL_W         = 48;
    localparam int ID_W         = 32;
    localparam int CAPACITY_DEF = 32;
    localparam int MAX_RESULTS  = 32;
    localparam int SLOT_AW      = 6;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_EXPIRE = 2'd2;

    localparam logic [1:0] KIND_ADD     = 2'd0;
    localparam logic [1:0] KIND_CANCEL  = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    typedef struct packed {
        logic [DL_W-1:0] dl;
        logic [ID_W-1:0] id;
    } slot_t;

    typedef struct packed {
        logic               wr_en;
        logic [SLOT_AW-1:0] wr_addr;
        slot_t              wr_data;
        logic [SLOT_AW-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] id;
        logic            first;
        logic            found;
        logic            full;
        logic [DL_W-1:0] next_dl;
        logic            last;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_CHK, S_REMOVE, S_TAIL, S_UP, S_UPC,
        S_DN, S_DNL, S_DNR, S_DNC, S_FIN, S_OUT
    } seq_state_t;

endpackage

// ===== rtl/deadline_min_heap_timer_queue.sv =====
// Top level of the deadline-ordered timer queue.
// Binary min-heap of up to CAPACITY timers (48-bit deadline, 32-bit id), one
// operation per input beat: add, cancel or expire. The block takes one input
// beat at a time and is not ready until its last result beat is taken. All
// heap work goes through one slot memory (one write port, one read port with
// registered read) and, for sift steps, one shared deadline comparator under
// a sequencer. Add: insertion at the tail, then a sift up. Cancel: a linear
// search of the slots, then a removal. Expire: one result beat per popped
// timer (at most 32), each a removal from the root; when nothing is due one
// beat of kind "nothing expired" follows. Every result beat carries the
// earliest remaining deadline, zero when empty, and last marks the final beat
// of an input.
module deadline_min_heap_timer_queue #(
    parameter int CAPACITY = dmh_pkg::CAPACITY_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               operation,
    input  logic [dmh_pkg::DL_W-1:0] deadline,
    input  logic [dmh_pkg::ID_W-1:0] cancel_id,
    input  logic [dmh_pkg::DL_W-1:0] now_time,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               kind,
    output logic [dmh_pkg::ID_W-1:0] timer_id,
    output logic                     first_to_expire,
    output logic                     found,
    output logic                     heap_full,
    output logic [dmh_pkg::DL_W-1:0] next_deadline,
    output logic                     last
);
    import dmh_pkg::*;

    res_t            res;
    mem_req_t        req;
    slot_t           rd_data;
    logic [DL_W-1:0] cmp_a;
    logic [DL_W-1:0] cmp_b;
    logic            cmp_lt;
    logic [DL_W-1:0] root_dl_reg;
    logic [ID_W-1:0] root_id_reg;

    // Shadow the root slot so the earliest deadline is always at hand.
    always_ff @(posedge clk)
    begin
        if (req.wr_en && req.wr_addr == '0)
        begin
            root_dl_reg <= req.wr_data.dl;
            root_id_reg <= req.wr_data.id;
        end
    end

    dmh_store #(.CAPACITY(CAPACITY)) u_store (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    dmh_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .lt (cmp_lt)
    );

    dmh_seq #(.CAPACITY(CAPACITY)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .deadline  (deadline),
        .cancel_id (cancel_id),
        .now_time  (now_time),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res),
        .req       (req),
        .rd_data   (rd_data),
        .root_dl   (root_dl_reg),
        .root_id   (root_id_reg),
        .cmp_a     (cmp_a),
        .cmp_b     (cmp_b),
        .cmp_lt    (cmp_lt)
    );

    assign kind            = res.kind;
    assign timer_id        = res.id;
    assign first_to_expire = res.first;
    assign found           = res.found;
    assign heap_full       = res.full;
    assign next_deadline   = res.next_dl;
    assign last            = res.last;

endmodule

// ===== rtl/dmh_store.sv =====
// Heap slot memory: one write port, one read port with registered data.
module dmh_store #(
    parameter int CAPACITY = dmh_pkg::CAPACITY_DEF
) (
    input  logic              clk,
    input  dmh_pkg::mem_req_t req,
    output dmh_pkg::slot_t    rd_data
);
    import dmh_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    slot_t mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        rd_data <= mem[req.rd_addr[AW-1:0]];
    end

endmodule

// ===== rtl/dmh_cmp.sv =====
// Shared deadline comparator used by every sift step.
module dmh_cmp (
    input  logic [dmh_pkg::DL_W-1:0] a,
    input  logic [dmh_pkg::DL_W-1:0] b,
    output logic                     lt
);
    import dmh_pkg::*;

    assign lt = (a < b);

endmodule

// ===== rtl/dmh_seq.sv =====
// Sequencer: add, cancel search, expire loop, sift up and sift down.
module dmh_seq #(
    parameter int CAPACITY = dmh_pkg::CAPACITY_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               operation,
    input  logic [dmh_pkg::DL_W-1:0] deadline,
    input  logic [dmh_pkg::ID_W-1:0] cancel_id,
    input  logic [dmh_pkg::DL_W-1:0] now_time,
    output logic                     out_valid,
    input  logic                     out_ready,
    output dmh_pkg::res_t            res,
    output dmh_pkg::mem_req_t        req,
    input  dmh_pkg::slot_t           rd_data,
    input  logic [dmh_pkg::DL_W-1:0] root_dl,
    input  logic [dmh_pkg::ID_W-1:0] root_id,
    output logic [dmh_pkg::DL_W-1:0] cmp_a,
    output logic [dmh_pkg::DL_W-1:0] cmp_b,
    input  logic                     cmp_lt
);
    import dmh_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = AW + 2;
    localparam int PW = $clog2(MAX_RESULTS + 1);

    seq_state_t      state_reg, state_next;
    logic [1:0]      op_reg, op_next;
    logic [DL_W-1:0] now_reg, now_next;
    logic [ID_W-1:0] cid_reg, cid_next;
    slot_t           cur_reg, cur_next;
    slot_t           pick_reg, pick_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic [AW-1:0]   scan_reg, scan_next;
    logic [AW-1:0]   pidx_reg, pidx_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [ID_W-1:0] idc_reg, idc_next;
    logic [PW-1:0]   pops_reg, pops_next;
    logic [ID_W-1:0] popid_reg, popid_next;
    logic            remf_reg, remf_next;
    logic            hit_reg, hit_next;
    logic            first_reg, first_next;
    res_t            res_reg, res_next;

    logic [AW-1:0]   par;
    logic [KW-1:0]   kid;
    logic [KW-1:0]   kid1;
    logic [KW-1:0]   count_k;
    logic [CW-1:0]   tail;
    logic [DL_W-1:0] nd;
    logic            more;

    assign par     = AW'((pos_reg - 1'b1) >> 1);
    assign kid     = {1'b0, pos_reg, 1'b1};
    assign kid1    = kid + 1'b1;
    assign count_k = KW'(count_reg);
    assign tail    = count_reg - 1'b1;
    assign nd      = (count_reg != '0) ? root_dl : '0;
    assign more    = (pops_reg < PW'(MAX_RESULTS)) && (count_reg != '0)
                     && !(now_reg < root_dl);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idc_reg   <= idc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        now_reg   <= now_next;
        cid_reg   <= cid_next;
        cur_reg   <= cur_next;
        pick_reg  <= pick_next;
        pos_reg   <= pos_next;
        scan_reg  <= scan_next;
        pidx_reg  <= pidx_next;
        pops_reg  <= pops_next;
        popid_reg <= popid_next;
        remf_reg  <= remf_next;
        hit_reg   <= hit_next;
        first_reg <= first_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        now_next    = now_reg;
        cid_next    = cid_reg;
        cur_next    = cur_reg;
        pick_next   = pick_reg;
        pos_next    = pos_reg;
        scan_next   = scan_reg;
        pidx_next   = pidx_reg;
        count_next  = count_reg;
        idc_next    = idc_reg;
        pops_next   = pops_reg;
        popid_next  = popid_reg;
        remf_next   = remf_reg;
        hit_next    = hit_reg;
        first_next  = first_reg;
        res_next    = res_reg;
        req.wr_en   = 1'b0;
        req.wr_addr = SLOT_AW'(pos_reg);
        req.wr_data = cur_reg;
        req.rd_addr = '0;
        cmp_a       = cur_reg.dl;
        cmp_b       = rd_data.dl;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = operation;
                    now_next = now_time;
                    cid_next = cancel_id;
                    hit_next = 1'b0;
                    case (operation)
                        OP_ADD:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                res_next   = '{KIND_ADD, '0, 1'b0, 1'b0, 1'b1, nd, 1'b1};
                                state_next = S_OUT;
                            end
                            else
                            begin
                                first_next = (count_reg != '0) && (deadline < root_dl);
                                idc_next   = idc_reg + 1'b1;
                                cur_next   = '{deadline, idc_reg + 1'b1};
                                pos_next   = AW'(count_reg);
                                count_next = count_reg + 1'b1;
                                remf_next  = 1'b0;
                                state_next = S_UP;
                            end
                        end
                        OP_CANCEL:
                        begin
                            scan_next   = '0;
                            req.rd_addr = '0;
                            state_next  = (count_reg == '0) ? S_FIN : S_SCAN;
                        end
                        OP_EXPIRE:
                        begin
                            pops_next  = '0;
                            state_next = S_CHK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (rd_data.id == cid_reg)
                begin
                    pos_next   = scan_reg;
                    hit_next   = 1'b1;
                    state_next = S_REMOVE;
                end
                else if ((CW'(scan_reg) + 1'b1) < count_reg)
                begin
                    scan_next   = scan_reg + 1'b1;
                    req.rd_addr = SLOT_AW'(scan_reg + 1'b1);
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_CHK:
            begin
                if (more)
                begin
                    popid_next = root_id;
                    pos_next   = '0;
                    pops_next  = pops_reg + 1'b1;
                    state_next = S_REMOVE;
                end
                else
                begin
                    res_next   = '{KIND_NONE, '0, 1'b0, 1'b0, 1'b0, nd, 1'b1};
                    state_next = S_OUT;
                end
            end
            S_REMOVE:
            begin
                count_next  = tail;
                req.rd_addr = SLOT_AW'(tail);
                state_next  = (CW'(pos_reg) == tail) ? S_FIN : S_TAIL;
            end
            S_TAIL:
            begin
                cur_next   = rd_data;
                remf_next  = 1'b1;
                state_next = (pos_reg == '0) ? S_DN : S_UP;
            end
            S_UP:
            begin
                if (pos_reg == '0)
                begin
                    req.wr_en  = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    req.rd_addr = SLOT_AW'(par);
                    state_next  = S_UPC;
                end
            end
            S_UPC:
            begin
                // move the parent down into the hole while the entry is earlier
                if (cmp_lt)
                begin
                    req.wr_en   = 1'b1;
                    req.wr_data = rd_data;
                    pos_next    = par;
                    remf_next   = 1'b0;
                    state_next  = S_UP;
                end
                else if (remf_reg)
                begin
                    remf_next  = 1'b0;
                    state_next = S_DN;
                end
                else
                begin
                    req.wr_en  = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_DN:
            begin
                if (kid < count_k)
                begin
                    req.rd_addr = SLOT_AW'(kid);
                    state_next  = S_DNL;
                end
                else
                begin
                    req.wr_en  = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_DNL:
            begin
                pick_next = rd_data;
                pidx_next = AW'(kid);
                if (kid1 < count_k)
                begin
                    req.rd_addr = SLOT_AW'(kid1);
                    state_next  = S_DNR;
                end
                else
                begin
                    state_next = S_DNC;
                end
            end
            S_DNR:
            begin
                // take the right child when it is not later than the left
                cmp_a = pick_reg.dl;
                cmp_b = rd_data.dl;
                if (!cmp_lt)
                begin
                    pick_next = rd_data;
                    pidx_next = AW'(kid1);
                end
                state_next = S_DNC;
            end
            S_DNC:
            begin
                cmp_a = cur_reg.dl;
                cmp_b = pick_reg.dl;
                req.wr_en = 1'b1;
                if (cmp_lt)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    req.wr_data = pick_reg;
                    pos_next    = pidx_reg;
                    state_next  = S_DN;
                end
            end
            S_FIN:
            begin
                case (op_reg)
                    OP_ADD:
                        res_next = '{KIND_ADD, idc_reg, first_reg, 1'b0, 1'b0, nd, 1'b1};
                    OP_CANCEL:
                        res_next = '{KIND_CANCEL, '0, 1'b0, hit_reg, 1'b0, nd, 1'b1};
                    default:
                        res_next = '{KIND_EXPIRED, popid_reg, 1'b0, 1'b0, 1'b0, nd, !more};
                endcase
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = (op_reg == OP_EXPIRE && !res_reg.last) ? S_CHK : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/dmh_chk.sv =====
// Port-level checker for the timer queue and its bind.
module dmh_chk (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [1:0]               kind,
    input logic [dmh_pkg::ID_W-1:0] timer_id,
    input logic                     first_to_expire,
    input logic                     heap_full,
    input logic                     last
);
    import dmh_pkg::*;

    // never take an input beat while a result beat is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid)
        else $error("input taken while result pending");

    // hold a stalled result beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(timer_id) && $stable(kind))
        else $error("stalled result changed");

    // only expired beats may leave last low
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_EXPIRED |-> last)
        else $error("single-result reply without last");

    // a rejected add carries no id and no first flag
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ADD && heap_full |-> timer_id == '0 && !first_to_expire)
        else $error("rejected add carries data");

endmodule

bind deadline_min_heap_timer_queue dmh_chk u_dmh_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .timer_id        (timer_id),
    .first_to_expire (first_to_expire),
    .heap_full       (heap_full),
    .last            (last)
);
